>>> rtl/tse_pkg.sv
package tse_pkg;

  localparam int unsigned MAX_RES = 8;

  localparam logic [15:0] CH_CR  = 16'h000D;
  localparam logic [15:0] CH_LF  = 16'h000A;
  localparam logic [15:0] CH_SP  = 16'h0020;
  localparam logic [15:0] CH_LT  = 16'h003C;
  localparam logic [15:0] CH_AMP = 16'h0026;
  localparam logic [15:0] CH_BOM = 16'hFEFF;

  typedef enum logic [1:0] {
    MODE_SEEK_TU,
    MODE_SEEK_SEG,
    MODE_IN_SEG,
    MODE_SKIP
  } tse_mode_t;

  typedef struct packed {
    tse_mode_t   mode;
    logic [2:0]  prog;
    logic [1:0]  ent;
    logic        in_ent;
    logic        cr_held;
    logic        at_start;
  } tse_state_t;

  // one queue entry: all characters produced by one input transfer
  typedef struct packed {
    logic [MAX_RES-1:0][15:0] ch;
    logic [3:0]               cnt;
  } tse_res_t;

  typedef struct packed {
    tse_state_t st;
    tse_res_t   res;
  } tse_work_t;

  function automatic logic [15:0] pat_tu(input logic [2:0] i);
    logic [15:0] c;
    unique case (i)
      3'd0:    c = 16'h003C;
      3'd1:    c = 16'h0074;
      3'd2:    c = 16'h0075;
      3'd3:    c = 16'h0020;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pat_seg(input logic [2:0] i);
    logic [15:0] c;
    unique case (i)
      3'd0:    c = 16'h003C;
      3'd1:    c = 16'h0073;
      3'd2:    c = 16'h0065;
      3'd3:    c = 16'h0067;
      3'd4:    c = 16'h003E;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pat_end(input logic [2:0] i);
    logic [15:0] c;
    unique case (i)
      3'd0:    c = 16'h003C;
      3'd1:    c = 16'h002F;
      3'd2:    c = 16'h0073;
      3'd3:    c = 16'h0065;
      3'd4:    c = 16'h0067;
      3'd5:    c = 16'h003E;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pat_ent(input logic [1:0] k, input logic [2:0] i);
    logic [15:0] c;
    c = 16'h0000;
    unique case (k)
      2'd0: begin
        unique case (i)
          3'd0:    c = 16'h0026;
          3'd1:    c = 16'h006C;
          3'd2:    c = 16'h0074;
          3'd3:    c = 16'h003B;
          default: c = 16'h0000;
        endcase
      end
      2'd1: begin
        unique case (i)
          3'd0:    c = 16'h0026;
          3'd1:    c = 16'h0067;
          3'd2:    c = 16'h0074;
          3'd3:    c = 16'h003B;
          default: c = 16'h0000;
        endcase
      end
      2'd2: begin
        unique case (i)
          3'd0:    c = 16'h0026;
          3'd1:    c = 16'h0061;
          3'd2:    c = 16'h006D;
          3'd3:    c = 16'h0070;
          3'd4:    c = 16'h003B;
          default: c = 16'h0000;
        endcase
      end
      default: begin
        unique case (i)
          3'd0:    c = 16'h0026;
          3'd1:    c = 16'h0071;
          3'd2:    c = 16'h0075;
          3'd3:    c = 16'h006F;
          3'd4:    c = 16'h0074;
          3'd5:    c = 16'h003B;
          default: c = 16'h0000;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] ent_len(input logic [1:0] k);
    logic [2:0] n;
    unique case (k)
      2'd0:    n = 3'd4;
      2'd1:    n = 3'd4;
      2'd2:    n = 3'd5;
      default: n = 3'd6;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] ent_val(input logic [1:0] k);
    logic [15:0] c;
    unique case (k)
      2'd0:    c = 16'h003C;
      2'd1:    c = 16'h003E;
      2'd2:    c = 16'h0026;
      default: c = 16'h0022;
    endcase
    return c;
  endfunction

  function automatic tse_res_t res_push(input tse_res_t r, input logic [15:0] c);
    tse_res_t o;
    o = r;
    if (r.cnt < 4'd8) begin
      o.ch[r.cnt[2:0]] = c;
      o.cnt = r.cnt + 4'd1;
    end
    return o;
  endfunction

  function automatic tse_work_t flush_partial(input tse_work_t w);
    tse_work_t o;
    logic [2:0] p;
    o = w;
    p = (w.st.prog > 3'd6) ? 3'd6 : w.st.prog;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < p) begin
        o.res = res_push(o.res, w.st.in_ent ? pat_ent(w.st.ent, 3'(i)) : pat_end(3'(i)));
      end
    end
    o.st.prog   = 3'd0;
    o.st.in_ent = 1'b0;
    return o;
  endfunction

  function automatic tse_work_t seg_char(input tse_work_t w, input logic [15:0] c);
    tse_work_t o;
    logic       done;
    logic       found;
    logic [2:0] len;
    o     = w;
    done  = 1'b0;
    found = 1'b0;
    len   = ent_len(w.st.ent);
    if (w.st.prog != 3'd0 && !w.st.in_ent) begin
      if (w.st.prog < 3'd6 && c == pat_end(w.st.prog)) begin
        done = 1'b1;
        o.st.prog = w.st.prog + 3'd1;
        if (o.st.prog == 3'd6) begin
          o.res = res_push(o.res, CH_CR);
          o.res = res_push(o.res, CH_LF);
          o.st.prog = 3'd0;
          o.st.mode = MODE_SKIP;
        end
      end else begin
        o = flush_partial(o);
      end
    end else if (w.st.prog != 3'd0) begin
      if (w.st.prog == 3'd1) begin
        for (int k = 0; k < 4; k++) begin
          if (!found && c == pat_ent(2'(k), 3'd1)) begin
            found     = 1'b1;
            o.st.ent  = 2'(k);
            o.st.prog = 3'd2;
          end
        end
        done = found;
      end else if (w.st.prog < len && c == pat_ent(w.st.ent, w.st.prog)) begin
        done = 1'b1;
        o.st.prog = w.st.prog + 3'd1;
        if (o.st.prog == len) begin
          o.res = res_push(o.res, ent_val(w.st.ent));
          o.st.prog   = 3'd0;
          o.st.in_ent = 1'b0;
        end
      end
      if (!done) begin
        o = flush_partial(o);
      end
    end
    if (!done) begin
      if (c == CH_LT) begin
        o.st.prog   = 3'd1;
        o.st.in_ent = 1'b0;
      end else if (c == CH_AMP) begin
        o.st.prog   = 3'd1;
        o.st.in_ent = 1'b1;
        o.st.ent    = 2'd0;
      end else begin
        o.res = res_push(o.res, c);
      end
    end
    return o;
  endfunction

  function automatic tse_work_t plain_char(input tse_work_t w, input logic [15:0] c);
    tse_work_t o;
    o = w;
    unique case (w.st.mode)
      MODE_SEEK_TU: begin
        if (w.st.prog < 3'd4 && c == pat_tu(w.st.prog)) begin
          o.st.prog = w.st.prog + 3'd1;
          if (o.st.prog == 3'd4) begin
            o.st.prog   = 3'd0;
            o.st.in_ent = 1'b0;
            o.st.mode   = MODE_SEEK_SEG;
          end
        end else begin
          o.st.prog = (c == pat_tu(3'd0)) ? 3'd1 : 3'd0;
        end
      end
      MODE_SEEK_SEG: begin
        if (w.st.prog < 3'd5 && c == pat_seg(w.st.prog)) begin
          o.st.prog = w.st.prog + 3'd1;
          if (o.st.prog == 3'd5) begin
            o.st.prog   = 3'd0;
            o.st.in_ent = 1'b0;
            o.st.mode   = MODE_IN_SEG;
          end
        end else begin
          o.st.prog = (c == pat_seg(3'd0)) ? 3'd1 : 3'd0;
        end
      end
      MODE_IN_SEG: o = seg_char(w, c);
      MODE_SKIP:   o = w;
    endcase
    return o;
  endfunction

  function automatic tse_work_t line_end(input tse_work_t w);
    tse_work_t o;
    o = w;
    if (w.st.mode == MODE_IN_SEG) begin
      o = flush_partial(o);
      o.res = res_push(o.res, CH_SP);
    end else if (w.st.mode == MODE_SKIP) begin
      o.st.mode = MODE_SEEK_TU;
    end
    o.st.prog    = 3'd0;
    o.st.in_ent  = 1'b0;
    o.st.cr_held = 1'b0;
    return o;
  endfunction

endpackage

>>> rtl/tse_front.sv
module tse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [15:0]       in_char,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push,
  output tse_pkg::tse_res_t push_data
);
  import tse_pkg::*;

  tse_state_t state;
  tse_state_t state_next;
  tse_work_t  w;
  logic       take;

  assign take = in_valid && !q_full;

  always_comb begin
    w           = '0;
    w.st        = state;
    w.st.at_start = 1'b0;
    if (!(state.at_start && in_char == CH_BOM)) begin
      if (state.cr_held && in_char == CH_LF) begin
        w = line_end(w);
      end else begin
        if (state.cr_held) begin
          w.st.cr_held = 1'b0;
          w = plain_char(w, CH_CR);
        end
        if (in_char == CH_CR) begin
          w.st.cr_held = 1'b1;
        end else if (in_char == CH_LF) begin
          w = line_end(w);
        end else begin
          w = plain_char(w, in_char);
        end
      end
    end
  end

  always_comb begin
    state_next = take ? w.st : state;
  end

  always_comb begin
    in_ready  = !q_full;
    push      = take && (w.res.cnt != 4'd0);
    push_data = w.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_SEEK_TU, prog: 3'd0, ent: 2'd0, in_ent: 1'b0,
                 cr_held: 1'b0, at_start: 1'b1};
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/tse_queue.sv
module tse_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tse_pkg::tse_res_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output tse_pkg::tse_res_t head
);
  import tse_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tse_res_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/tse_back.sv
module tse_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  tse_pkg::tse_res_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_char,
  output logic              out_last
);
  import tse_pkg::*;

  logic [2:0] pos;
  logic       fire;

  assign out_valid = !q_empty;
  assign out_char  = head.ch[pos];
  assign out_last  = ({1'b0, pos} == head.cnt - 4'd1);
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (fire) begin
      pos <= out_last ? 3'd0 : pos + 3'd1;
    end
  end

endmodule

>>> rtl/tmx_segment_text_extractor_core.sv
// channel | dir | tdata                       | tuser | tlast
// s_      | in  | [15:0] in_char              | -     | -
// m_      | out | [15:0] out_char             | -     | last_of_run
//
// Input takes one code unit per cycle while the result queue has room.
// Output gives one code unit per cycle while m_tready is high and the queue is not empty;
// an input yielding n units holds its queue entry until all n are sent; the output side sets sustained rate.
// Units that yield no result take no queue entry.
// Reset is synchronous; after it the queue is empty and s_tready is high.
module tmx_segment_text_extractor_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] in_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] out_char
  output logic        m_tlast
);
  import tse_pkg::*;

  logic     push;
  tse_res_t push_data;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  tse_res_t head;

  tse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_char   (s_tdata),
    .q_full    (q_full),
    .in_ready  (s_tready),
    .push      (push),
    .push_data (push_data)
  );

  tse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  tse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> rtl/tse_checker.sv
module tse_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input transfer changed while stalled");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready right after reset");

endmodule

bind tmx_segment_text_extractor_core tse_checker u_tse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
